[src/assert_macros.svh]
// Assertion macros shared by the texture slot binner modules.
// Each macro expects signals named clk and arst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define TSB_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("texture slot binner: check failed");

// Next-cycle implication, checked out of reset.
`define TSB_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("texture slot binner: check failed");

`endif

[src/tsb_pkg.sv]
// Package for the texture slot binner: field widths, codes, controller states
// and the command/status structs between controller and datapath. No dependencies.
package tsb_pkg;

	localparam int TexW     = 32;
	localparam int VtxW     = 64;
	localparam int FillW    = 18;
	localparam int IdxCntW  = 19;
	localparam int SlotW    = 5;
	localparam int FuncW    = 3;
	localparam int KindW    = 2;
	localparam int ModeW    = 2;
	localparam int PrimW    = 16;
	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 32;

	// Input function codes.
	typedef enum logic [FuncW-1:0] {
		FN_VERTEX    = 3'd0,
		FN_BIND      = 3'd1,
		FN_WHITE     = 3'd2,
		FN_BATCH     = 3'd3,
		FN_FLUSH_ALL = 3'd4
	} func_t;

	// Result kinds.
	typedef enum logic [KindW-1:0] {
		KIND_PLACE = 2'd0,
		KIND_FLUSH = 2'd1,
		KIND_BIND  = 2'd2,
		KIND_BATCH = 2'd3
	} kind_t;

	// Draw modes.
	typedef enum logic [ModeW-1:0] {
		MODE_POINTS    = 2'd0,
		MODE_LINES     = 2'd1,
		MODE_TRIANGLES = 2'd2,
		MODE_QUADS     = 2'd3
	} mode_t;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] CFG_DRAW_MODE = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_BUF_PRIM  = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_WHITE_ID  = 2'd2;

	localparam logic [PrimW-1:0] BUF_PRIM_RST = 16'd1024;
	localparam logic [TexW-1:0]  WHITE_ID_RST = 32'd0;

	typedef struct packed {
		mode_t             draw_mode;
		logic [PrimW-1:0]  buf_prim;
		logic [TexW-1:0]   white_id;
	} cfg_t;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_VTX,
		ST_VTX_PLACE,
		ST_BIND_SCAN,
		ST_BIND_HIT,
		ST_BIND_EVICT,
		ST_BIND_NEW,
		ST_WHITE,
		ST_BATCH,
		ST_FLUSH_ALL
	} state_t;

	// Which result the datapath builds when it loads the output register.
	typedef enum logic [2:0] {
		RES_FLUSH,
		RES_PLACE,
		RES_HIT,
		RES_NEW,
		RES_WHITE,
		RES_BATCH
	} res_sel_t;

	// Slot table read address source.
	typedef enum logic [1:0] {
		ADDR_ACTIVE,
		ADDR_SCAN,
		ADDR_BEST
	} addr_sel_t;

	typedef struct packed {
		logic      load_item;
		logic      scan_clr;
		logic      scan_inc;
		logic      track;
		logic      emit;
		res_sel_t  res_sel;
		addr_sel_t addr_sel;
		logic      last;
		logic      clr_fill;
		logic      inc_fill;
		logic      evict;
		logic      bind_new;
		logic      act_scan;
		logic      act_zero;
		logic      new_batch;
	} dp_cmd_t;

	typedef struct packed {
		logic can_emit;
		logic need_flush;
		logic hit_now;
		logic free_any;
		logic valid_now;
		logic more_valid;
		logic scan_end;
	} dp_stat_t;

endpackage

[src/tsb_cmd_if.sv]
// Input channel of the texture slot binner: valid/ready plus one command item.
// Depends on tsb_pkg for field widths.
interface tsb_cmd_if import tsb_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [FuncW-1:0]    func;
	logic [TexW-1:0]     tex_id;
	logic [VtxW-1:0]     vertex_word;

	modport source(output valid, func, tex_id, vertex_word, input ready);
	modport sink(input valid, func, tex_id, vertex_word, output ready);
endinterface

[src/tsb_res_if.sv]
// Output channel of the texture slot binner: valid/ready plus one result item.
// Depends on tsb_pkg for field widths.
interface tsb_res_if import tsb_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [KindW-1:0]    kind;
	logic [SlotW-1:0]    slot;
	logic [TexW-1:0]     slot_texture_id;
	logic [FillW-1:0]    position;
	logic [IdxCntW-1:0]  elem_count;
	logic                draw_ok;
	logic                hit;
	logic [VtxW-1:0]     vertex_out;
	logic                last;

	modport source(output valid, kind, slot, slot_texture_id, position, elem_count,
		draw_ok, hit, vertex_out, last, input ready);
	modport sink(input valid, kind, slot, slot_texture_id, position, elem_count,
		draw_ok, hit, vertex_out, last, output ready);
endinterface

[src/tsb_dp.sv]
// Datapath of the texture slot binner: slot table, scan tracking and output register.
// Depends on tsb_pkg, tsb_res_if and assert_macros.svh.
`include "assert_macros.svh"

module tsb_dp import tsb_pkg::*; #(
	parameter int SLOTS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  dp_cmd_t          c,
	output dp_stat_t         st,
	input  logic [TexW-1:0]  tex_id,
	input  logic [VtxW-1:0]  vertex_word,
	tsb_res_if.source        res
);

	localparam int IW   = $clog2(SLOTS);
	localparam int CapW = FillW + 1;
	localparam logic [SLOTS-1:0] VALID_RST = SLOTS'(1);

	// True when v is a multiple of three: base-4 digit sums keep the residue.
	function automatic logic mult3(input logic [FillW-1:0] v);
		logic [4:0] s;
		logic [2:0] r;
		s = '0;
		for (int k = 0; k < FillW / 2; k++) s = s + 5'(v[2*k +: 2]);
		r = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
		return (r == 3'd0) || (r == 3'd3) || (r == 3'd6);
	endfunction

	logic [SLOTS-1:0]  valid_q;
	logic [TexW-1:0]   tex_q [SLOTS];
	logic [FillW-1:0]  fill_q [SLOTS];
	logic [IW-1:0]     active_q;
	logic [IW-1:0]     scan_q;
	logic              free_found_q;
	logic [IW-1:0]     free_q;
	logic [IW-1:0]     best_q;
	logic [FillW-1:0]  maxc_q;
	logic [TexW-1:0]   tid_q;
	logic [VtxW-1:0]   vtx_q;

	logic               res_valid_q;
	logic [KindW-1:0]   res_kind_q;
	logic [SlotW-1:0]   res_slot_q;
	logic [TexW-1:0]    res_tex_q;
	logic [FillW-1:0]   res_pos_q;
	logic [IdxCntW-1:0] res_idx_q;
	logic               res_ok_q;
	logic               res_hit_q;
	logic [VtxW-1:0]    res_vtx_q;
	logic               res_last_q;

	logic [IW-1:0]      rd_idx;
	logic [FillW-1:0]   rd_fill;
	logic [TexW-1:0]    rd_tex;
	logic [IW-1:0]      target;
	logic [2:0]         align;
	logic [CapW-1:0]    cap;
	logic [CapW-1:0]    fill_sum;
	logic [IdxCntW-1:0] flush_idx;
	logic               flush_ok;
	logic               free_now;
	logic               more_valid;
	logic               emit_go;

	logic [KindW-1:0]   nx_kind;
	logic [SlotW-1:0]   nx_slot;
	logic [TexW-1:0]    nx_tex;
	logic [FillW-1:0]   nx_pos;
	logic [IdxCntW-1:0] nx_idx;
	logic               nx_ok;
	logic               nx_hit;
	logic [VtxW-1:0]    nx_vtx;

	// Single read port into the slot table.
	always_comb begin
		unique case (c.addr_sel)
			ADDR_SCAN: rd_idx = scan_q;
			ADDR_BEST: rd_idx = best_q;
			default:   rd_idx = active_q;
		endcase
	end

	assign rd_fill = fill_q[rd_idx];
	assign rd_tex  = (rd_idx == '0) ? cfg.white_id : tex_q[rd_idx];
	assign target  = free_found_q ? free_q : best_q;

	// Buffer capacity check for the next vertex.
	assign align    = {1'b0, cfg.draw_mode} + 3'd1;
	assign cap      = CapW'(cfg.buf_prim) * CapW'(align);
	assign fill_sum = CapW'(rd_fill) + CapW'(align);

	// Draw figures of a flushed slot.
	always_comb begin
		if (cfg.draw_mode == MODE_QUADS)
			flush_idx = IdxCntW'({rd_fill[FillW-1:2], 2'b00})
				+ IdxCntW'({rd_fill[FillW-1:2], 1'b0});
		else
			flush_idx = IdxCntW'(rd_fill);
		case (cfg.draw_mode)
			MODE_LINES:     flush_ok = ~rd_fill[0];
			MODE_TRIANGLES: flush_ok = mult3(rd_fill);
			MODE_QUADS:     flush_ok = (rd_fill[1:0] == 2'b00);
			default:        flush_ok = 1'b1;
		endcase
	end

	// Scan status.
	assign free_now = !valid_q[scan_q] && (scan_q != '0);
	always_comb begin
		more_valid = 1'b0;
		for (int i = 0; i < SLOTS; i++)
			if (valid_q[i] && (IW'(i) > scan_q)) more_valid = 1'b1;
	end

	assign emit_go = c.emit;

	assign st.can_emit   = !res_valid_q || res.ready;
	assign st.need_flush = (fill_sum >= cap);
	assign st.hit_now    = valid_q[scan_q] && (rd_tex == tid_q);
	assign st.free_any   = free_found_q || free_now;
	assign st.valid_now  = valid_q[scan_q];
	assign st.more_valid = more_valid;
	assign st.scan_end   = (scan_q == IW'(SLOTS - 1));

	// Result builder.
	always_comb begin
		nx_kind = KIND_FLUSH;
		nx_slot = SlotW'(rd_idx);
		nx_tex  = rd_tex;
		nx_pos  = '0;
		nx_idx  = '0;
		nx_ok   = 1'b0;
		nx_hit  = 1'b0;
		nx_vtx  = '0;
		case (c.res_sel)
			RES_FLUSH: begin
				nx_pos = rd_fill;
				nx_idx = flush_idx;
				nx_ok  = flush_ok;
			end
			RES_PLACE: begin
				nx_kind = KIND_PLACE;
				nx_pos  = rd_fill;
				nx_vtx  = vtx_q;
			end
			RES_HIT: begin
				nx_kind = KIND_BIND;
				nx_hit  = 1'b1;
			end
			RES_NEW: begin
				nx_kind = KIND_BIND;
				nx_slot = SlotW'(target);
				nx_tex  = tid_q;
			end
			RES_WHITE: begin
				nx_kind = KIND_BIND;
				nx_slot = '0;
				nx_tex  = cfg.white_id;
				nx_hit  = 1'b1;
			end
			RES_BATCH: begin
				nx_kind = KIND_BATCH;
				nx_slot = '0;
				nx_tex  = cfg.white_id;
			end
			default: nx_kind = KIND_FLUSH;
		endcase
	end

	// Slot table control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= VALID_RST;
			fill_q   <= '{default: '0};
			active_q <= '0;
		end else if (emit_go && c.new_batch) begin
			valid_q  <= VALID_RST;
			fill_q   <= '{default: '0};
			active_q <= '0;
		end else if (emit_go) begin
			if (c.clr_fill) fill_q[rd_idx] <= '0;
			if (c.inc_fill) fill_q[rd_idx] <= rd_fill + FillW'(1);
			if (c.evict) valid_q[best_q] <= 1'b0;
			if (c.bind_new) begin
				valid_q[target] <= 1'b1;
				active_q        <= target;
			end
			if (c.act_scan) active_q <= scan_q;
			if (c.act_zero) active_q <= '0;
		end
	end

	// Texture ids of the slots; undefined until bound.
	always_ff @(posedge clk) begin
		if (emit_go && c.bind_new) tex_q[target] <= tid_q;
	end

	// Scan counter and free-slot tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q       <= '0;
			free_found_q <= 1'b0;
		end else if (c.scan_clr) begin
			scan_q       <= '0;
			free_found_q <= 1'b0;
		end else begin
			if (c.scan_inc) scan_q <= scan_q + IW'(1);
			if (c.track && free_now && !free_found_q) free_found_q <= 1'b1;
		end
	end

	// Eviction candidate and item payload.
	always_ff @(posedge clk) begin
		if (c.load_item) begin
			tid_q <= tex_id;
			vtx_q <= vertex_word;
		end
		if (c.scan_clr) begin
			best_q <= IW'(1);
			maxc_q <= '0;
		end else if (c.track) begin
			if (free_now && !free_found_q) free_q <= scan_q;
			if ((scan_q != '0) && (rd_fill > maxc_q)) begin
				best_q <= scan_q;
				maxc_q <= rd_fill;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_valid_q <= 1'b0;
		else if (emit_go) res_valid_q <= 1'b1;
		else if (res.ready) res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			res_kind_q <= nx_kind;
			res_slot_q <= nx_slot;
			res_tex_q  <= nx_tex;
			res_pos_q  <= nx_pos;
			res_idx_q  <= nx_idx;
			res_ok_q   <= nx_ok;
			res_hit_q  <= nx_hit;
			res_vtx_q  <= nx_vtx;
			res_last_q <= c.last;
		end
	end

	assign res.valid           = res_valid_q;
	assign res.kind            = res_kind_q;
	assign res.slot            = res_slot_q;
	assign res.slot_texture_id = res_tex_q;
	assign res.position        = res_pos_q;
	assign res.elem_count      = res_idx_q;
	assign res.draw_ok         = res_ok_q;
	assign res.hit             = res_hit_q;
	assign res.vertex_out      = res_vtx_q;
	assign res.last            = res_last_q;

	// Slot 0 holds the white texture at all times.
	`TSB_ASSERT_IMP(a_slot0_valid, 1'b1, valid_q[0])
	// A newly bound slot was free beforehand.
	`TSB_ASSERT_IMP(a_bind_free, emit_go && c.bind_new, !valid_q[target])

endmodule

[src/tsb_ctrl.sv]
// Controller of the texture slot binner: sequences each command over the datapath.
// Depends on tsb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tsb_ctrl import tsb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  logic [FuncW-1:0]  func,
	output logic              cmd_ready,
	input  dp_stat_t          st,
	output dp_cmd_t           c
);

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_nx;
	end

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					case (func_t'(func))
						FN_VERTEX:    state_nx = ST_VTX;
						FN_BIND:      state_nx = ST_BIND_SCAN;
						FN_WHITE:     state_nx = ST_WHITE;
						FN_BATCH:     state_nx = ST_BATCH;
						FN_FLUSH_ALL: state_nx = ST_FLUSH_ALL;
						default:      state_nx = ST_IDLE;
					endcase
				end
			end
			ST_VTX: begin
				if (st.can_emit) state_nx = st.need_flush ? ST_VTX_PLACE : ST_IDLE;
			end
			ST_VTX_PLACE: begin
				if (st.can_emit) state_nx = ST_IDLE;
			end
			ST_BIND_SCAN: begin
				if (st.hit_now) state_nx = ST_BIND_HIT;
				else if (st.scan_end) state_nx = st.free_any ? ST_BIND_NEW : ST_BIND_EVICT;
			end
			ST_BIND_HIT: begin
				if (st.can_emit) state_nx = ST_IDLE;
			end
			ST_BIND_EVICT: begin
				if (st.can_emit) state_nx = ST_BIND_NEW;
			end
			ST_BIND_NEW, ST_WHITE, ST_BATCH: begin
				if (st.can_emit) state_nx = ST_IDLE;
			end
			ST_FLUSH_ALL: begin
				if (st.valid_now) begin
					if (st.can_emit && !st.more_valid) state_nx = ST_IDLE;
				end else if (st.scan_end) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd_ready = 1'b0;
		c         = '0;
		c.res_sel  = RES_PLACE;
		c.addr_sel = ADDR_ACTIVE;
		unique case (state_q)
			ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					c.load_item = 1'b1;
					c.scan_clr  = 1'b1;
				end
			end
			ST_VTX: begin
				if (st.can_emit) begin
					c.emit = 1'b1;
					if (st.need_flush) begin
						c.res_sel  = RES_FLUSH;
						c.clr_fill = 1'b1;
					end else begin
						c.inc_fill = 1'b1;
						c.last     = 1'b1;
					end
				end
			end
			ST_VTX_PLACE: begin
				c.emit     = st.can_emit;
				c.inc_fill = 1'b1;
				c.last     = 1'b1;
			end
			ST_BIND_SCAN: begin
				c.addr_sel = ADDR_SCAN;
				if (!st.hit_now) begin
					c.track    = 1'b1;
					c.scan_inc = !st.scan_end;
				end
			end
			ST_BIND_HIT: begin
				c.addr_sel = ADDR_SCAN;
				c.res_sel  = RES_HIT;
				c.emit     = st.can_emit;
				c.act_scan = 1'b1;
				c.last     = 1'b1;
			end
			ST_BIND_EVICT: begin
				c.addr_sel = ADDR_BEST;
				c.res_sel  = RES_FLUSH;
				c.emit     = st.can_emit;
				c.clr_fill = 1'b1;
				c.evict    = 1'b1;
			end
			ST_BIND_NEW: begin
				c.res_sel  = RES_NEW;
				c.emit     = st.can_emit;
				c.bind_new = 1'b1;
				c.last     = 1'b1;
			end
			ST_WHITE: begin
				c.res_sel  = RES_WHITE;
				c.emit     = st.can_emit;
				c.act_zero = 1'b1;
				c.last     = 1'b1;
			end
			ST_BATCH: begin
				c.res_sel   = RES_BATCH;
				c.emit      = st.can_emit;
				c.new_batch = 1'b1;
				c.last      = 1'b1;
			end
			ST_FLUSH_ALL: begin
				c.addr_sel = ADDR_SCAN;
				c.res_sel  = RES_FLUSH;
				if (st.valid_now) begin
					if (st.can_emit) begin
						c.emit     = 1'b1;
						c.clr_fill = 1'b1;
						c.last     = !st.more_valid;
						c.scan_inc = st.more_valid;
					end
				end else begin
					c.scan_inc = !st.scan_end;
				end
			end
			default: cmd_ready = 1'b0;
		endcase
	end

	// A result is loaded only when the output register can take it.
	`TSB_ASSERT_IMP(a_emit_room, c.emit, st.can_emit)
	// The slot scan never runs past the last slot.
	`TSB_ASSERT_IMP(a_scan_bound, c.scan_inc, !st.scan_end)

endmodule

[src/texture_slot_batch_binner_top.sv]
// Usage notes:
// The block bins vertices into SLOTS texture slots. Commands arrive on the cmd
// channel (valid/ready, transfer when both are high); results leave on the res
// channel in the same handshake, one transfer per result, last set on the final
// result of a command. Configuration is a plain write port (cfg_we, cfg_index,
// cfg_wdata); the user must write it only while the block is idle, which the
// block itself does not enforce. A command is taken in the idle state, after
// which the controller works it through the datapath; the next command is taken
// once every result of this one has been loaded into the output register.
// Vertex placement emits a place result, preceded by a flush result when the
// slot must be flushed first. A bind scans the table one slot per cycle over the
// single read port, with a flush result first if it must evict. Flush-all walks
// the slots at one per cycle while the receiver does not stall.
// Reset makes slot 0 the only valid slot (it holds white_texture_id), clears all
// fill counts, selects slot 0 and loads the register defaults. When the receiver
// stalls, a result waits in the output register and the controller holds.

// Top level of the texture slot binner; holds the configuration registers.
// Depends on tsb_pkg, tsb_cmd_if, tsb_res_if, tsb_ctrl and tsb_dp.
module texture_slot_batch_binner_top import tsb_pkg::*; #(
	parameter int SLOTS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CfgIdxW-1:0]   cfg_index,
	input  logic [CfgDataW-1:0]  cfg_wdata,
	tsb_cmd_if.sink              cmd,
	tsb_res_if.source            res
);

	cfg_t     cfg_q;
	dp_cmd_t  dcmd;
	dp_stat_t dstat;
	logic     cmd_ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.draw_mode <= MODE_TRIANGLES;
			cfg_q.buf_prim  <= BUF_PRIM_RST;
			cfg_q.white_id  <= WHITE_ID_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DRAW_MODE: cfg_q.draw_mode <= mode_t'(cfg_wdata[ModeW-1:0]);
				CFG_BUF_PRIM:  cfg_q.buf_prim  <= cfg_wdata[PrimW-1:0];
				CFG_WHITE_ID:  cfg_q.white_id  <= cfg_wdata[TexW-1:0];
				default:       cfg_q.white_id  <= cfg_q.white_id;
			endcase
		end
	end

	assign cmd.ready = cmd_ready;

	tsb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.func      (cmd.func),
		.cmd_ready (cmd_ready),
		.st        (dstat),
		.c         (dcmd)
	);

	tsb_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.c           (dcmd),
		.st          (dstat),
		.tex_id      (cmd.tex_id),
		.vertex_word (cmd.vertex_word),
		.res         (res)
	);

endmodule
